// ===== hw/rtl/srt_pkg.sv =====
// Sector range table: shared types, operation and status codes, widths.
// Used by srt_alu, srt_core and sector_range_table_unit.
package srt_pkg;

    localparam int SECT_W   = 32;
    localparam int TYPE_W   = 8;
    localparam int NUM_CFG  = 4;
    localparam int ALU_W    = 36;
    localparam int FREE_W   = 41;
    localparam int SECT_SHIFT = 9;

    typedef enum logic [2:0] {
        OP_CREATE  = 3'd0,
        OP_DELETE  = 3'd1,
        OP_RESIZE  = 3'd2,
        OP_SETTYPE = 3'd3,
        OP_CLR_MBR = 3'd4,
        OP_CLR_GPT = 3'd5,
        OP_READ    = 3'd6,
        OP_FREE    = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD     = 2'd1,
        ST_BEYOND  = 2'd2,
        ST_OVERLAP = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK,
        S_RD,
        S_EV,
        S_WR,
        S_FIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [TYPE_W-1:0] part_type;
        logic [SECT_W-1:0] length_sectors;
        logic [SECT_W-1:0] start_sector;
    } t_entry;

    typedef struct packed {
        t_op               op;
        logic [1:0]        disk;
        logic [2:0]        entry_index;
        logic [SECT_W-1:0] start_sector;
        logic [SECT_W-1:0] length_sectors;
        logic [TYPE_W-1:0] part_type;
    } t_item;

    typedef struct packed {
        t_status           status;
        logic [2:0]        assigned_index;
        logic [SECT_W-1:0] entry_start;
        logic [SECT_W-1:0] entry_length;
        logic [TYPE_W-1:0] entry_type;
        logic [2:0]        entry_count;
        logic              table_kind;
        logic [FREE_W-1:0] free_bytes;
    } t_result;

endpackage

// ===== hw/rtl/srt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srt_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 28,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic [AW-1:0]        i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/srt_alu.sv =====
// Shared add/subtract unit of the sector range table sequencer.
// Depends on srt_pkg.
module srt_alu (
    input  logic [srt_pkg::ALU_W-1:0] i_a,
    input  logic [srt_pkg::ALU_W-1:0] i_b,
    input  logic                      i_sub,
    output logic [srt_pkg::ALU_W:0]   o_sum
);
    logic [srt_pkg::ALU_W-1:0] b_eff;

    assign b_eff = i_sub ? ~i_b : i_b;
    assign o_sum = {1'b0, i_a} + {1'b0, b_eff} + (srt_pkg::ALU_W + 1)'(i_sub);

endmodule

// ===== hw/rtl/srt_core.sv =====
// Sector range table sequencer: per-disk counts and kinds, entry walk over the
// entry RAM through one shared adder, output word register.
// Depends on srt_pkg and srt_alu.
module srt_core #(
    parameter int MAX_ENTRIES = 7,
    parameter int NUM_DISKS   = 4,
    localparam int DEPTH      = NUM_DISKS * MAX_ENTRIES,
    localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_item_valid,
    output logic                          o_item_ready,
    input  srt_pkg::t_item                i_item,
    input  logic [srt_pkg::SECT_W-1:0]    i_sectors [srt_pkg::NUM_CFG],
    output logic                          o_ram_we,
    output logic [AW-1:0]                 o_ram_waddr,
    output srt_pkg::t_entry               o_ram_wdata,
    output logic [AW-1:0]                 o_ram_raddr,
    input  srt_pkg::t_entry               i_ram_rdata,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output srt_pkg::t_result              o_res
);
    localparam int CW    = $clog2(MAX_ENTRIES + 1);
    localparam int DW    = (NUM_DISKS > 1) ? $clog2(NUM_DISKS) : 1;
    localparam int EW    = srt_pkg::SECT_W + 1;

    srt_pkg::t_state  r_state, n_state;
    srt_pkg::t_item   r_item, n_item;
    srt_pkg::t_result r_work, n_work;
    srt_pkg::t_result r_out, n_out;
    logic             r_out_valid, n_out_valid;
    logic [CW-1:0]    r_i, n_i;
    logic [EW-1:0]    r_end, n_end;
    logic [srt_pkg::ALU_W-1:0] r_acc, n_acc;
    logic [CW-1:0]    r_cnt [NUM_DISKS];
    logic [CW-1:0]    n_cnt [NUM_DISKS];
    logic             r_kind [NUM_DISKS];
    logic             n_kind [NUM_DISKS];

    logic                      disk_ok;
    logic [DW-1:0]             dsel;
    logic [CW-1:0]             cur_cnt;
    logic                      cur_kind;
    logic [EW-1:0]             total;
    logic                      idx_ok;
    logic                      del_more;
    logic                      take;
    logic [31:0]               base;
    logic [CW:0]               rd_off;
    logic [CW-1:0]             wr_off;
    logic [srt_pkg::ALU_W-1:0] alu_a, alu_b;
    logic                      alu_sub;
    logic [srt_pkg::ALU_W:0]   alu_sum;
    logic [EW-1:0]             ps, pe, ss;
    logic                      clash;

    srt_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_sub (alu_sub),
        .o_sum (alu_sum)
    );

    assign disk_ok  = 32'(r_item.disk) < NUM_DISKS;
    assign dsel     = DW'(r_item.disk);
    assign cur_cnt  = disk_ok ? r_cnt[dsel] : '0;
    assign cur_kind = disk_ok ? r_kind[dsel] : 1'b0;
    assign total    = EW'(i_sectors[r_item.disk]);
    assign idx_ok   = 32'(r_item.entry_index) < 32'(cur_cnt);
    assign del_more = (32'(r_item.entry_index) + 32'd1) < 32'(cur_cnt);
    assign take     = (r_state == srt_pkg::S_DONE) && (!r_out_valid || i_res_ready);
    assign base     = 32'(r_item.disk) * 32'(MAX_ENTRIES);
    assign rd_off   = (CW + 1)'(r_i) + (CW + 1)'(r_item.op == srt_pkg::OP_DELETE);
    assign wr_off   = (r_state == srt_pkg::S_WR) ? cur_cnt : r_i;
    assign o_ram_raddr = AW'(base + 32'(rd_off));
    assign o_ram_waddr = AW'(base + 32'(wr_off));

    assign ps    = EW'(i_ram_rdata.start_sector);
    assign pe    = alu_sum[EW-1:0];
    assign ss    = EW'(r_item.start_sector);
    assign clash = (ss >= ps && ss < pe) || (r_end > ps && r_end <= pe)
                || (ss <= ps && r_end >= pe);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            srt_pkg::S_IDLE: begin
                if (i_item_valid) n_state = srt_pkg::S_CHK;
            end
            srt_pkg::S_CHK: begin
                if (!disk_ok) begin
                    n_state = srt_pkg::S_DONE;
                end else begin
                    unique case (r_item.op)
                        srt_pkg::OP_CREATE: begin
                            if (32'(cur_cnt) >= MAX_ENTRIES) n_state = srt_pkg::S_DONE;
                            else if (alu_sum[EW-1:0] > total) n_state = srt_pkg::S_DONE;
                            else if (cur_cnt == '0) n_state = srt_pkg::S_WR;
                            else n_state = srt_pkg::S_RD;
                        end
                        srt_pkg::OP_DELETE: begin
                            n_state = del_more ? srt_pkg::S_RD : srt_pkg::S_DONE;
                        end
                        srt_pkg::OP_RESIZE, srt_pkg::OP_SETTYPE, srt_pkg::OP_READ: begin
                            n_state = idx_ok ? srt_pkg::S_RD : srt_pkg::S_DONE;
                        end
                        srt_pkg::OP_FREE: begin
                            n_state = (cur_cnt == '0) ? srt_pkg::S_FIN : srt_pkg::S_RD;
                        end
                        default: n_state = srt_pkg::S_DONE;
                    endcase
                end
            end
            srt_pkg::S_RD: n_state = srt_pkg::S_EV;
            srt_pkg::S_EV: begin
                unique case (r_item.op)
                    srt_pkg::OP_CREATE: begin
                        if (clash) n_state = srt_pkg::S_DONE;
                        else if ((32'(r_i) + 32'd1) < 32'(cur_cnt)) n_state = srt_pkg::S_RD;
                        else n_state = srt_pkg::S_WR;
                    end
                    srt_pkg::OP_DELETE: begin
                        // count already holds the reduced value
                        n_state = ((32'(r_i) + 32'd1) < 32'(cur_cnt)) ? srt_pkg::S_RD
                                                                       : srt_pkg::S_DONE;
                    end
                    srt_pkg::OP_FREE: begin
                        n_state = ((32'(r_i) + 32'd1) < 32'(cur_cnt)) ? srt_pkg::S_RD
                                                                       : srt_pkg::S_FIN;
                    end
                    default: n_state = srt_pkg::S_DONE;
                endcase
            end
            srt_pkg::S_WR:  n_state = srt_pkg::S_DONE;
            srt_pkg::S_FIN: n_state = srt_pkg::S_DONE;
            srt_pkg::S_DONE: begin
                if (take) n_state = srt_pkg::S_IDLE;
            end
            default: n_state = srt_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_item      = r_item;
        n_work      = r_work;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        n_i         = r_i;
        n_end       = r_end;
        n_acc       = r_acc;
        n_cnt       = r_cnt;
        n_kind      = r_kind;
        alu_a       = '0;
        alu_b       = '0;
        alu_sub     = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_wdata = i_ram_rdata;

        if (r_out_valid && i_res_ready) n_out_valid = 1'b0;

        unique case (r_state)
            srt_pkg::S_IDLE: begin
                if (i_item_valid) begin
                    n_item = i_item;
                    n_work = '0;
                end
            end
            srt_pkg::S_CHK: begin
                alu_a = srt_pkg::ALU_W'(r_item.start_sector);
                alu_b = srt_pkg::ALU_W'(r_item.length_sectors);
                n_end = alu_sum[EW-1:0];
                n_acc = '0;
                n_i   = '0;
                if (!disk_ok) begin
                    n_work.status = srt_pkg::ST_BAD;
                end else begin
                    unique case (r_item.op)
                        srt_pkg::OP_CREATE: begin
                            if (32'(cur_cnt) >= MAX_ENTRIES)
                                n_work.status = srt_pkg::ST_BAD;
                            else if (alu_sum[EW-1:0] > total)
                                n_work.status = srt_pkg::ST_BEYOND;
                        end
                        srt_pkg::OP_DELETE: begin
                            n_i = CW'(r_item.entry_index);
                            if (!idx_ok) n_work.status = srt_pkg::ST_BAD;
                            else n_cnt[dsel] = cur_cnt - CW'(1);
                        end
                        srt_pkg::OP_RESIZE, srt_pkg::OP_SETTYPE, srt_pkg::OP_READ: begin
                            n_i = CW'(r_item.entry_index);
                            if (!idx_ok) n_work.status = srt_pkg::ST_BAD;
                        end
                        srt_pkg::OP_CLR_MBR, srt_pkg::OP_CLR_GPT: begin
                            n_cnt[dsel]  = '0;
                            n_kind[dsel] = (r_item.op == srt_pkg::OP_CLR_GPT);
                        end
                        default: ;
                    endcase
                end
            end
            srt_pkg::S_EV: begin
                unique case (r_item.op)
                    srt_pkg::OP_CREATE: begin
                        alu_a = srt_pkg::ALU_W'(i_ram_rdata.start_sector);
                        alu_b = srt_pkg::ALU_W'(i_ram_rdata.length_sectors);
                        if (clash) n_work.status = srt_pkg::ST_OVERLAP;
                        n_i = r_i + CW'(1);
                    end
                    srt_pkg::OP_DELETE: begin
                        o_ram_we = 1'b1;
                        n_i      = r_i + CW'(1);
                    end
                    srt_pkg::OP_RESIZE: begin
                        alu_a = srt_pkg::ALU_W'(i_ram_rdata.start_sector);
                        alu_b = srt_pkg::ALU_W'(r_item.length_sectors);
                        o_ram_wdata.length_sectors = r_item.length_sectors;
                        if (alu_sum[EW-1:0] > total) n_work.status = srt_pkg::ST_BEYOND;
                        else o_ram_we = 1'b1;
                    end
                    srt_pkg::OP_SETTYPE: begin
                        o_ram_wdata.part_type = r_item.part_type;
                        o_ram_we = 1'b1;
                    end
                    srt_pkg::OP_READ: begin
                        n_work.entry_start  = i_ram_rdata.start_sector;
                        n_work.entry_length = i_ram_rdata.length_sectors;
                        n_work.entry_type   = i_ram_rdata.part_type;
                    end
                    srt_pkg::OP_FREE: begin
                        alu_a = r_acc;
                        alu_b = srt_pkg::ALU_W'(i_ram_rdata.length_sectors);
                        n_acc = alu_sum[srt_pkg::ALU_W-1:0];
                        n_i   = r_i + CW'(1);
                    end
                    default: ;
                endcase
            end
            srt_pkg::S_WR: begin
                o_ram_we    = 1'b1;
                o_ram_wdata = '{part_type:      r_item.part_type,
                                length_sectors: r_item.length_sectors,
                                start_sector:   r_item.start_sector};
                n_work.assigned_index = 3'(cur_cnt);
                n_cnt[dsel] = cur_cnt + CW'(1);
            end
            srt_pkg::S_FIN: begin
                alu_a   = srt_pkg::ALU_W'(total);
                alu_b   = r_acc;
                alu_sub = 1'b1;
                // carry out set means total >= used
                if (alu_sum[srt_pkg::ALU_W] && alu_sum[srt_pkg::ALU_W-1:0] != '0)
                    n_work.free_bytes = {alu_sum[srt_pkg::SECT_W-1:0],
                                         srt_pkg::SECT_SHIFT'(0)};
            end
            srt_pkg::S_DONE: begin
                if (take) begin
                    n_out             = r_work;
                    n_out.entry_count = 3'(cur_cnt);
                    n_out.table_kind  = cur_kind;
                    n_out_valid       = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srt_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '{default: '0};
            r_kind      <= '{default: 1'b0};
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            r_kind      <= n_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_work <= n_work;
        r_out  <= n_out;
        r_i    <= n_i;
        r_end  <= n_end;
        r_acc  <= n_acc;
    end

    assign o_item_ready = (r_state == srt_pkg::S_IDLE);
    assign o_res_valid  = r_out_valid;
    assign o_res        = r_out;

`ifndef NO_ASSERTIONS
    a_accept_to_chk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item_valid && o_item_ready) |=> (r_state == srt_pkg::S_CHK))
        else $error("accepted word did not start a check");
    a_we_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_we |-> (r_state == srt_pkg::S_EV || r_state == srt_pkg::S_WR))
        else $error("entry write outside write states");
    a_append_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srt_pkg::S_WR) |=> (cur_cnt == CW'($past(cur_cnt) + 1'b1)))
        else $error("append did not bump entry count");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != srt_pkg::S_IDLE) |-> (32'(cur_cnt) <= MAX_ENTRIES))
        else $error("entry count beyond table size");
`endif

endmodule

// ===== hw/rtl/sector_range_table_unit.sv =====
// Each word is checked first; clear, bad disk, bad index, full or beyond disk end there. Read,
// resize and set type read and evaluate their entry; create walks every entry, ending early
// on overlap, else appends; delete shifts later entries down; free sums lengths, then subtracts.
// Throughput: one word at a time; ready again the cycle after the result register loads; the
// walk reads and evaluates entries in turn through one RAM read port and one shared adder.
// Reset (sync, active low): counts zero, kinds MBR, disk sizes zero, no word pending; RAM kept.
module sector_range_table_unit #(
    parameter int MAX_ENTRIES = 7,
    parameter int NUM_DISKS   = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [79:0]  s_axis_tdata,  // disk, entry_index, start_sector, length_sectors,
                                        // part_type, zero pad
    input  logic [2:0]   s_axis_tuser,  // op
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,  // status, assigned_index, entry_start, entry_length,
                                        // entry_type, entry_count, table_kind, free_bytes,
                                        // zero pad
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    localparam int DEPTH = NUM_DISKS * MAX_ENTRIES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [srt_pkg::SECT_W-1:0] r_sect [srt_pkg::NUM_CFG];
    srt_pkg::t_item   item;
    srt_pkg::t_result res;
    srt_pkg::t_entry  ram_wdata, ram_rdata;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr, ram_raddr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sect <= '{default: '0};
        end else if (i_cfg_valid) begin
            r_sect[i_cfg_index] <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    assign item.op             = srt_pkg::t_op'(s_axis_tuser);
    assign item.disk           = s_axis_tdata[1:0];
    assign item.entry_index    = s_axis_tdata[4:2];
    assign item.start_sector   = s_axis_tdata[36:5];
    assign item.length_sectors = s_axis_tdata[68:37];
    assign item.part_type      = s_axis_tdata[76:69];

    srt_ram #(
        .WIDTH ($bits(srt_pkg::t_entry)),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    srt_core #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .NUM_DISKS   (NUM_DISKS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (s_axis_tvalid),
        .o_item_ready (s_axis_tready),
        .i_item       (item),
        .i_sectors    (r_sect),
        .o_ram_we     (ram_we),
        .o_ram_waddr  (ram_waddr),
        .o_ram_wdata  (ram_wdata),
        .o_ram_raddr  (ram_raddr),
        .i_ram_rdata  (ram_rdata),
        .o_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .o_res        (res)
    );

    assign m_axis_tdata = {6'd0, res.free_bytes, res.table_kind, res.entry_count,
                           res.entry_type, res.entry_length, res.entry_start,
                           res.assigned_index, res.status};

endmodule
